// File: hw/rtl/adip_pkg.sv
package adip_pkg;

  // Field length limit; position saturates here.
  localparam int MAX_FIELD_LEN = 4096;
  localparam int POS_W         = 13;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_END    = 2'd1;
  localparam logic [1:0] ST_NONNUM = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      value;
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } out_item_t;

endpackage

// File: hw/rtl/adip_core.sv
module adip_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  adip_pkg::in_item_t item,
  input  logic              signed_mode,
  output logic              res_valid,
  output adip_pkg::out_item_t res
);

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_NUM  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  localparam logic [adip_pkg::POS_W-1:0] POS_MAX = adip_pkg::POS_W'(adip_pkg::MAX_FIELD_LEN);

  phase_t                      phase_r, phase_nxt;
  logic [31:0]                 acc_r, acc_nxt;
  logic                        neg_r, neg_nxt;
  logic                        seen_r, seen_nxt;
  logic [adip_pkg::POS_W-1:0]  pos_r, pos_nxt;

  logic [7:0]                  c;
  logic                        last;
  logic                        is_space, is_digit;
  logic [3:0]                  dval;
  logic [31:0]                 acc_x10;
  logic [adip_pkg::POS_W-1:0]  endpos;

  assign c        = item.char_code;
  assign last     = item.is_last;
  assign is_space = (c == adip_pkg::CH_NUL) || (c == adip_pkg::CH_SPACE) ||
                    (c == adip_pkg::CH_LF);
  assign is_digit = (c >= adip_pkg::CH_ZERO) && (c <= adip_pkg::CH_NINE);
  assign dval     = 4'(c - adip_pkg::CH_ZERO);
  // x10 as shift-add
  assign acc_x10  = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0};
  assign endpos   = (pos_r < POS_MAX) ? pos_r + 1'b1 : pos_r;

  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    seen_nxt     = seen_r;
    res_valid    = 1'b0;
    res.status   = adip_pkg::ST_OK;
    res.position = endpos;
    case (phase_r)
      PH_SKIP: begin
        if (is_space) begin
          if (last) begin
            res_valid  = 1'b1;
            res.status = adip_pkg::ST_END;
          end
        end else if (signed_mode && c == adip_pkg::CH_MINUS) begin
          neg_nxt   = 1'b1;
          res_valid = last;
          phase_nxt = PH_NUM;
        end else if (signed_mode && c == adip_pkg::CH_PLUS) begin
          neg_nxt   = 1'b0;
          res_valid = last;
          phase_nxt = PH_NUM;
        end else if (is_digit) begin
          acc_nxt   = {28'd0, dval};
          seen_nxt  = 1'b1;
          res_valid = last;
          phase_nxt = PH_NUM;
        end else begin
          res_valid    = 1'b1;
          res.status   = adip_pkg::ST_NONNUM;
          res.position = pos_r;
          phase_nxt    = PH_DONE;
        end
      end
      PH_NUM: begin
        if (is_digit) begin
          acc_nxt   = acc_x10 + {28'd0, dval};
          seen_nxt  = 1'b1;
          res_valid = last;
        end else if (c == adip_pkg::CH_UNDER) begin
          res_valid = last;
        end else begin
          res_valid    = 1'b1;
          res.position = pos_r;
          phase_nxt    = PH_DONE;
          if (!(is_space || seen_r)) begin
            res.status = adip_pkg::ST_NONNUM;
          end
        end
      end
      default: begin
        // done, and unused code: wait for field end
      end
    endcase
    // value from the updated accumulator, taken before the field-end clear
    if (res.status == adip_pkg::ST_OK) begin
      res.value = neg_nxt ? (32'd0 - acc_nxt) : acc_nxt;
    end else begin
      res.value = 32'd0;
    end
    pos_nxt   = endpos;
    if (last) begin
      phase_nxt = PH_SKIP;
      acc_nxt   = 32'd0;
      neg_nxt   = 1'b0;
      seen_nxt  = 1'b0;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      acc_r   <= 32'd0;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      seen_r  <= seen_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// File: hw/rtl/adip_out_reg.sv
module adip_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  adip_pkg::out_item_t load_data,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output adip_pkg::out_item_t out_data
);

  logic                valid_r, valid_nxt;
  adip_pkg::out_item_t data_r;

  // slot frees in the same cycle the held result transfers
  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

// File: hw/rtl/ascii_decimal_integer_parser.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready   | in_data   (char_code, is_last)
// out_    | output    | out_valid / out_ready | out_data  (value, status, position)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_data  (signed_mode)
//
// One character per cycle sustained unless out_ stalls; a result is presented
// on out_ after its character has passed the input and result registers.
// The parse step (x10 shift-add plus digit) sits between those two registers.
// Reset (rst_n low, synchronous) empties both registers, sets signed_mode and
// returns the parser to skipping leading whitespace at index 0.
// A stalled output holds the result; the input register keeps moving while
// the result register is free or being drained this cycle.
module ascii_decimal_integer_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  adip_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output adip_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic               signed_mode_r;
  logic               s1_valid_r, s1_valid_nxt;
  adip_pkg::in_item_t s1_data_r;
  logic               slot_free;
  logic               step;
  logic               res_valid;
  adip_pkg::out_item_t res;

  // Register write is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
    end else if (cfg_valid) begin
      signed_mode_r <= cfg_data;
    end
  end

  // Input register advances whenever the result slot can take a result.
  assign step         = s1_valid_r && slot_free;
  assign in_ready     = !s1_valid_r || slot_free;
  assign s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (s1_valid_r && !slot_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  adip_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (s1_data_r),
    .signed_mode (signed_mode_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  adip_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .load_data (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Drives framed character streams into the decimal parser and checks every
// result against a cycle-free model of the scan held in this module.
module testbench;

  // No transfer on any channel for this many cycles ends the run.
  localparam int WATCHDOG_LIMIT = 2000;
  // A result passes through the input and result registers; leave some margin so a
  // character that yields nothing has fully left the pipe.
  localparam int SETTLE_CYCLES = 6;

  typedef enum logic [1:0] {
    SCAN_LEAD   = 2'd0,  // skipping leading blanks
    SCAN_DIGITS = 2'd1,  // sign or digits taken, number in progress
    SCAN_DONE   = 2'd2   // result out, ignoring rest of the field
  } scan_state_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  adip_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  adip_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  ascii_decimal_integer_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scan model: own copy of the register and the per-field state
  // ---------------------------------------------------------------------------
  logic        sign_allowed = 1'b1;  // signed_mode, reset value 1
  scan_state_t scan_state = SCAN_LEAD;
  logic [31:0] acc_value = '0;
  logic        minus_seen = 1'b0;
  logic        have_digit = 1'b0;
  int          char_idx = 0;

  adip_pkg::out_item_t awaited_parses[$];  // results predicted, not yet seen

  int fail_count = 0;
  int results_checked = 0;
  int chars_sent = 0;
  int fields_sent = 0;
  int idle_cycles = 0;

  // Idling knobs, in percent per cycle.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  logic [7:0] field_buf[$];  // characters of the field about to be sent

  function automatic bit is_blank(input logic [7:0] c);
    return (c == adip_pkg::CH_NUL) || (c == adip_pkg::CH_SPACE) ||
           (c == adip_pkg::CH_LF);
  endfunction

  function automatic bit is_dec_digit(input logic [7:0] c);
    return (c >= adip_pkg::CH_ZERO) && (c <= adip_pkg::CH_NINE);
  endfunction

  function automatic logic [31:0] scanned_number();
    return minus_seen ? (32'd0 - acc_value) : acc_value;
  endfunction

  task automatic clear_scan();
    scan_state = SCAN_LEAD;
    acc_value  = '0;
    minus_seen = 1'b0;
    have_digit = 1'b0;
    char_idx   = 0;
  endtask

  // Advance the scan by one character; queue the result it produces, if any.
  task automatic parse_char(input adip_pkg::in_item_t it);
    logic [7:0]          c;
    int                  here;
    int                  after;
    bit                  emit_now;
    bit                  rejected;
    adip_pkg::out_item_t res;
    c        = it.char_code;
    here     = char_idx;
    // saturating index
    after    = (here < adip_pkg::MAX_FIELD_LEN) ? here + 1 : here;
    emit_now = 1'b0;
    rejected = 1'b0;
    res      = '0;
    case (scan_state)
      SCAN_LEAD: begin
        if (is_blank(c)) begin
          // field of blanks only
          if (it.is_last) begin
            emit_now     = 1'b1;
            res.status   = adip_pkg::ST_END;
            res.position = after[adip_pkg::POS_W-1:0];
          end
        end else begin
          if (sign_allowed && c == adip_pkg::CH_MINUS) begin
            minus_seen = 1'b1;
          end else if (sign_allowed && c == adip_pkg::CH_PLUS) begin
            minus_seen = 1'b0;
          end else if (is_dec_digit(c)) begin
            acc_value  = 32'(c - adip_pkg::CH_ZERO);
            have_digit = 1'b1;
          end else begin
            rejected = 1'b1;  // includes '_' first and sign in unsigned mode
          end
          if (rejected) begin
            emit_now     = 1'b1;
            res.status   = adip_pkg::ST_NONNUM;
            res.position = here[adip_pkg::POS_W-1:0];
            scan_state   = SCAN_DONE;
          end else if (it.is_last) begin
            emit_now     = 1'b1;
            res.value    = scanned_number();
            res.status   = adip_pkg::ST_OK;
            res.position = after[adip_pkg::POS_W-1:0];
          end else begin
            scan_state = SCAN_DIGITS;
          end
        end
      end
      SCAN_DIGITS: begin
        if (is_dec_digit(c) || c == adip_pkg::CH_UNDER) begin
          if (is_dec_digit(c)) begin
            // wraps mod 2^32
            acc_value  = acc_value * 32'd10 + 32'(c - adip_pkg::CH_ZERO);
            have_digit = 1'b1;
          end
          if (it.is_last) begin
            emit_now     = 1'b1;
            res.value    = scanned_number();
            res.status   = adip_pkg::ST_OK;
            res.position = after[adip_pkg::POS_W-1:0];
          end
        end else if (is_blank(c) || have_digit) begin
          // terminator; a lone sign before a blank lands here with zero
          emit_now     = 1'b1;
          res.value    = scanned_number();
          res.status   = adip_pkg::ST_OK;
          res.position = here[adip_pkg::POS_W-1:0];
          scan_state   = SCAN_DONE;
        end else begin
          // junk after a sign, before any digit
          emit_now     = 1'b1;
          res.status   = adip_pkg::ST_NONNUM;
          res.position = here[adip_pkg::POS_W-1:0];
          scan_state   = SCAN_DONE;
        end
      end
      default: ;  // done: swallow until field end
    endcase
    if (it.is_last) clear_scan();
    else char_idx = after;
    if (emit_now) awaited_parses.push_back(res);
  endtask

  task automatic compare_parse(input adip_pkg::out_item_t got);
    adip_pkg::out_item_t want;
    if (awaited_parses.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: result with none pending: value %h status %0d position %0d",
                 $realtime, got.value, got.status, got.position);
    end else begin
      want = awaited_parses.pop_front();
      results_checked++;
      if (got.value !== want.value || got.status !== want.status ||
          got.position !== want.position) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: mismatch: expected value %h status %0d position %0d,",
                    " got value %h status %0d position %0d"},
                   $realtime, want.value, want.status, want.position,
                   got.value, got.status, got.position);
      end
    end
  endtask

  // One monitor for all three channels: every transfer is taken at the edge
  // it happens on, outputs first so a result can never match its own input.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) compare_parse(out_data);
      if (in_valid && in_ready) parse_char(in_data);
      if (cfg_valid && cfg_ready) sign_allowed = cfg_data;
    end
    if (rst_n && ((out_valid && out_ready) || (in_valid && in_ready) ||
                  (cfg_valid && cfg_ready)))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles, %0d results still pending",
             idle_cycles, awaited_parses.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver back-pressure.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One character transfer; leaves in_valid high on return.
  task automatic send_char(input logic [7:0] c, input bit last);
    adip_pkg::in_item_t it;
    it.char_code = c;
    it.is_last   = last;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_field();
    for (int i = 0; i < field_buf.size(); i++)
      send_char(field_buf[i], i == field_buf.size() - 1);
    fields_sent++;
  endtask

  task automatic send_text(input string s);
    field_buf.delete();
    for (int i = 0; i < s.len(); i++) field_buf.push_back(s[i]);
    send_field();
  endtask

  // Drop valid, wait out every pending result plus the pipe depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_parses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_signed_mode(input logic mode);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0:       return adip_pkg::CH_NUL;
      1:       return adip_pkg::CH_LF;
      default: return adip_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return adip_pkg::CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Mostly well-formed numbers with random content; some broken fields and
  // some pure noise.
  task automatic build_random_field();
    int kind;
    int ndig;
    kind = $urandom_range(99);
    field_buf.delete();
    if (kind < 70) begin
      repeat ($urandom_range(3)) field_buf.push_back(pick_blank());
      case ($urandom_range(3))
        0:       field_buf.push_back(adip_pkg::CH_MINUS);
        1:       field_buf.push_back(adip_pkg::CH_PLUS);
        default: ;
      endcase
      // now and then long enough to wrap the accumulator
      ndig = ($urandom_range(9) == 0) ? $urandom_range(11, 20)
                                       : $urandom_range(1, 10);
      for (int i = 0; i < ndig; i++) begin
        if (i > 0 && $urandom_range(7) == 0) field_buf.push_back(adip_pkg::CH_UNDER);
        field_buf.push_back(pick_digit());
      end
      case ($urandom_range(3))
        0:       ;  // no terminator after the digits
        1:       field_buf.push_back(pick_blank());
        2:       field_buf.push_back(8'($urandom_range(255)));
        default: field_buf.push_back(adip_pkg::CH_UNDER);
      endcase
      repeat ($urandom_range(3)) field_buf.push_back(8'($urandom_range(255)));
    end else if (kind < 85) begin
      repeat ($urandom_range(2)) field_buf.push_back(pick_blank());
      case ($urandom_range(3))
        0:       field_buf.push_back(adip_pkg::CH_MINUS);
        1:       field_buf.push_back(adip_pkg::CH_PLUS);
        2:       field_buf.push_back(adip_pkg::CH_UNDER);
        default: ;
      endcase
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(4))
          0:       field_buf.push_back(pick_digit());
          1:       field_buf.push_back(adip_pkg::CH_UNDER);
          2:       field_buf.push_back(pick_blank());
          3:       field_buf.push_back(adip_pkg::CH_MINUS);
          default: field_buf.push_back(8'($urandom_range(255)));
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) field_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int char_budget);
    int start;
    start = chars_sent;
    while (chars_sent - start < char_budget) begin
      build_random_field();
      send_field();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Signed mode, straight after reset.
  task automatic test_directed_signed();
    send_text("-12");
    send_text("+_5");   // separator after sign is skipped
    send_text("-");     // lone sign at field end
    send_text("- ");    // lone sign, then blank
    send_text("_1");    // separator before anything
    send_text("9x");    // junk after digits ends the number
    send_text("-a");    // junk after sign only
    send_text("5_");    // field ends on a separator
    send_text("0");
    field_buf.delete();  // blanks only
    field_buf.push_back(adip_pkg::CH_NUL);
    field_buf.push_back(adip_pkg::CH_LF);
    field_buf.push_back(adip_pkg::CH_SPACE);
    send_field();
    send_char(8'hFF, 1'b1);
    fields_sent++;
  endtask

  task automatic test_directed_unsigned();
    set_signed_mode(1'b0);
    send_text("-1");    // sign rejected
    send_text("+");
    send_text("8");
  endtask

  // Long fields: index runs past 150.
  task automatic test_long_fields();
    set_signed_mode(1'b1);
    field_buf.delete();
    repeat (150) field_buf.push_back(adip_pkg::CH_SPACE);
    send_field();
    field_buf.push_back("7");
    send_field();
    field_buf.delete();
    repeat (150) field_buf.push_back(pick_blank());
    field_buf.push_back(adip_pkg::CH_MINUS);
    field_buf.push_back("3");
    send_field();
  endtask

  task automatic test_random_no_idle();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(360);
  endtask

  task automatic test_random_sender_gaps();
    set_signed_mode(1'b0);
    send_gap_pct   = 63;
    recv_stall_pct = 0;
    run_random(360);
  endtask

  task automatic test_random_receiver_stalls();
    set_signed_mode(1'b1);
    send_gap_pct   = 0;
    recv_stall_pct = 63;
    run_random(360);
  endtask

  task automatic test_random_both();
    set_signed_mode(1'b0);
    send_gap_pct   = 12;
    recv_stall_pct = 12;
    run_random(360);
  endtask

  initial begin
    clear_scan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_signed();
    test_directed_unsigned();
    test_long_fields();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both();
    drain();

    $display("Sent %0d fields (%0d characters) in signed and unsigned mode, incl. long fields;",
             fields_sent, chars_sent);
    $display("checked %0d parse results under no idling, sender gaps, receiver stalls and both.",
             results_checked);
    if (fail_count == 0 && awaited_parses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, awaited_parses.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/adip_pkg.sv
hw/rtl/adip_core.sv
hw/rtl/adip_out_reg.sv
hw/rtl/ascii_decimal_integer_parser.sv
tb/sv/testbench.sv
